// ===== hw/rtl/qpd_pkg.sv =====
// ----------------------------------------------------------------------------
// qpd_pkg: shared types and constants of the query parameter decoder
// Result codes, character constants, the queue word and the hex helper.
// ----------------------------------------------------------------------------
package qpd_pkg;

  // Default sizes
  localparam int KEY_MAX_BYTES   = 16;
  localparam int KEY_STORE_BYTES = 16;
  localparam int QUEUE_DEPTH     = 4;

  // Result kinds
  localparam logic [1:0] KIND_BYTE       = 2'd0;
  localparam logic [1:0] KIND_END        = 2'd1;
  localparam logic [1:0] KIND_NOT_FOUND  = 2'd2;
  localparam logic [1:0] KIND_BAD_ESCAPE = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_KEY_LEN  = 2'd2;

  // Characters with a meaning in the value
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // One queue word: a result, optionally followed by a closing value-ended
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       closing;
    logic       plus_end;
  } qpd_entry_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } qpd_qstat_t;

  // Hex digit decode: bit 4 set when the byte is a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/qpd_front.sv =====
// ----------------------------------------------------------------------------
// qpd_front: key search and value decode
// Takes one byte a cycle while accept is high, matches the key window and classifies each byte
// into at most one queue word.
// ----------------------------------------------------------------------------
module qpd_front #(
  parameter int KEY_MAX_BYTES = qpd_pkg::KEY_MAX_BYTES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         in_byte,
  input  logic               is_final,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  output logic               push,
  output qpd_pkg::qpd_entry_t push_entry
);

  localparam int SEEN_W = $clog2(KEY_MAX_BYTES + 1);

  typedef enum logic [2:0] {
    PH_SEARCH = 3'b001,
    PH_VALUE  = 3'b010,
    PH_DONE   = 3'b100
  } phase_t;

  typedef enum logic [2:0] {
    ESC_NONE = 3'b001,
    ESC_PCT  = 3'b010,
    ESC_HEX1 = 3'b100
  } esc_t;

  logic [63:0]       key_low;
  logic [63:0]       key_high;
  logic [4:0]        key_len;
  logic [7:0]        key_arr [qpd_pkg::KEY_STORE_BYTES];
  logic [4:0]        key_n;

  logic [7:0]        window [KEY_MAX_BYTES];
  logic [7:0]        win_next [KEY_MAX_BYTES];
  logic [SEEN_W-1:0] seen, seen_next, seen_inc;
  phase_t            phase, phase_next;
  esc_t              esc, esc_next;
  logic [3:0]        hi_nib, hi_nib_next;
  logic [KEY_MAX_BYTES-1:0] lane_hit;
  logic              match;
  logic              shift;
  logic [4:0]        hex;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
      key_len  <= 5'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        qpd_pkg::REG_KEY_LOW:  key_low  <= cfg_data;
        qpd_pkg::REG_KEY_HIGH: key_high <= cfg_data;
        qpd_pkg::REG_KEY_LEN:  key_len  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Split the key into bytes
  for (genvar g = 0; g < qpd_pkg::KEY_STORE_BYTES; g++) begin : g_key
    if (g < 8) begin : g_lo
      assign key_arr[g] = key_low[8*g +: 8];
    end else begin : g_hi
      assign key_arr[g] = key_high[8*(g-8) +: 8];
    end
  end

  // Clamp the key length into 1..KEY_MAX_BYTES
  always_comb begin
    if (key_len == 5'd0) begin
      key_n = 5'd1;
    end else if (key_len > 5'(KEY_MAX_BYTES)) begin
      key_n = 5'(KEY_MAX_BYTES);
    end else begin
      key_n = key_len;
    end
  end

  // Window after this byte shifts in, newest at lane 0
  always_comb begin
    win_next[0] = in_byte;
    for (int i = 1; i < KEY_MAX_BYTES; i++) begin
      win_next[i] = window[i-1];
    end
  end

  assign seen_inc = (seen < SEEN_W'(KEY_MAX_BYTES)) ? seen + 1'b1 : seen;

  // Parallel compare: lane i holds key byte n-1-i
  for (genvar g = 0; g < KEY_MAX_BYTES; g++) begin : g_lane
    logic [4:0] kidx;
    assign kidx        = key_n - 5'(g + 1);
    assign lane_hit[g] = (5'(g) >= key_n) || (win_next[g] == key_arr[kidx[3:0]]);
  end

  assign match = (5'(seen_inc) >= key_n) && (&lane_hit);
  assign hex   = qpd_pkg::hex_digit(in_byte);

  // Classify the byte and work out the next state
  always_comb begin
    push        = 1'b0;
    push_entry  = '{kind: qpd_pkg::KIND_BYTE, data: 8'd0, closing: 1'b0, plus_end: 1'b0};
    phase_next  = phase;
    esc_next    = esc;
    hi_nib_next = hi_nib;
    seen_next   = seen;
    shift       = 1'b0;
    if (accept) begin
      unique case (phase)
        PH_SEARCH: begin
          shift     = 1'b1;
          seen_next = seen_inc;
          if (match) begin
            phase_next = PH_VALUE;
            if (is_final) begin
              push               = 1'b1;
              push_entry.kind    = qpd_pkg::KIND_END;
              push_entry.closing = 1'b1;
            end
          end else if (is_final) begin
            push               = 1'b1;
            push_entry.kind    = qpd_pkg::KIND_NOT_FOUND;
            push_entry.closing = 1'b1;
          end
        end
        PH_VALUE: begin
          unique case (esc) inside
            ESC_NONE: begin
              if (in_byte == qpd_pkg::CH_AMP) begin
                push               = 1'b1;
                push_entry.kind    = qpd_pkg::KIND_END;
                push_entry.closing = 1'b1;
                phase_next         = PH_DONE;
              end else if (in_byte == qpd_pkg::CH_PERCENT) begin
                esc_next = ESC_PCT;
                if (is_final) begin
                  push               = 1'b1;
                  push_entry.kind    = qpd_pkg::KIND_BAD_ESCAPE;
                  push_entry.closing = 1'b1;
                end
              end else begin
                push                = 1'b1;
                push_entry.data     = (in_byte == qpd_pkg::CH_PLUS) ? qpd_pkg::CH_SPACE
                                                                   : in_byte;
                push_entry.plus_end = is_final;
              end
            end
            ESC_PCT, ESC_HEX1: begin
              if (!hex[4]) begin
                push               = 1'b1;
                push_entry.kind    = qpd_pkg::KIND_BAD_ESCAPE;
                push_entry.closing = 1'b1;
                phase_next         = PH_DONE;
              end else if (esc == ESC_PCT) begin
                hi_nib_next = hex[3:0];
                esc_next    = ESC_HEX1;
                if (is_final) begin
                  push               = 1'b1;
                  push_entry.kind    = qpd_pkg::KIND_BAD_ESCAPE;
                  push_entry.closing = 1'b1;
                end
              end else begin
                push                = 1'b1;
                push_entry.data     = {hi_nib, hex[3:0]};
                push_entry.plus_end = is_final;
                esc_next            = ESC_NONE;
                hi_nib_next         = 4'd0;
              end
            end
            default: ;
          endcase
        end
        PH_DONE: ;
        default: ;
      endcase
      // Final byte: back to a fresh string
      if (is_final) begin
        phase_next  = PH_SEARCH;
        esc_next    = ESC_NONE;
        hi_nib_next = 4'd0;
        seen_next   = '0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_SEARCH;
      esc    <= ESC_NONE;
      hi_nib <= 4'd0;
      seen   <= '0;
    end else begin
      phase  <= phase_next;
      esc    <= esc_next;
      hi_nib <= hi_nib_next;
      seen   <= seen_next;
    end
  end

  // Window shift; lanes past the fill count never take part in a match
  always_ff @(posedge clk) begin
    if (shift) begin
      for (int i = 0; i < KEY_MAX_BYTES; i++) begin
        window[i] <= win_next[i];
      end
    end
  end

endmodule

// ===== hw/rtl/qpd_queue.sv =====
// ----------------------------------------------------------------------------
// qpd_queue: word queue between classifier and output side
// Small flip-flop FIFO; the classifier stalls while it is full.
// ----------------------------------------------------------------------------
module qpd_queue #(
  parameter int DEPTH = qpd_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  qpd_pkg::qpd_entry_t push_entry,
  input  logic                pop,
  output qpd_pkg::qpd_entry_t head,
  output qpd_pkg::qpd_qstat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  qpd_pkg::qpd_entry_t slots [DEPTH];
  logic [PTR_W-1:0]    wr_ptr, rd_ptr;
  logic [CNT_W-1:0]    count;

  assign head       = slots[rd_ptr];
  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/qpd_back.sv =====
// ----------------------------------------------------------------------------
// qpd_back: result output stage
// Drains queue words into the output register and expands a word that
// carries a trailing value-ended into two results.
// ----------------------------------------------------------------------------
module qpd_back (
  input  logic                clk,
  input  logic                rst,
  input  qpd_pkg::qpd_entry_t head,
  input  qpd_pkg::qpd_qstat_t stat,
  output logic                pop,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [1:0]          kind,
  output logic [7:0]          out_byte,
  output logic                closing
);

  logic pend_end;
  logic out_free;

  assign out_free = !out_valid || !out_stall;
  assign pop      = out_free && !pend_end && !stat.empty;

  // Load the next word when the output register frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_end  <= 1'b0;
    end else if (out_free) begin
      if (pend_end) begin
        out_valid <= 1'b1;
        pend_end  <= 1'b0;
      end else if (!stat.empty) begin
        out_valid <= 1'b1;
        pend_end  <= head.plus_end;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pend_end) begin
        kind     <= qpd_pkg::KIND_END;
        out_byte <= 8'd0;
        closing  <= 1'b1;
      end else if (!stat.empty) begin
        kind     <= head.kind;
        out_byte <= head.data;
        closing  <= head.closing;
      end
    end
  end

endmodule

// ===== hw/rtl/query_parameter_extract_decode.sv =====
// ----------------------------------------------------------------------------
// query_parameter_extract_decode: query parameter extractor and decoder
// Finds a configured key in a query string and emits its decoded value.
// ----------------------------------------------------------------------------
// The block takes one query byte per cycle: the key window is compared in
// parallel against all key bytes, so a byte is accepted every cycle while
// the word queue between the classifier and the output register has room.
// Each byte yields at most one queue word; a decoded byte that is also the
// final byte of the string yields two results (the byte, then value ended)
// from that one word at the output. The key bytes before a value yield
// no word, so a string never has more results than bytes and the queue
// absorbs that extra result: with the output always taken, a byte is
// accepted every cycle. Results pass the queue, then the output register.
// The user must write the key and its length on the configuration port
// between strings; the block itself does not enforce this. key_length 0
// acts as 1 and values above KEY_MAX_BYTES are clamped.
module query_parameter_extract_decode #(
  parameter int KEY_MAX_BYTES = qpd_pkg::KEY_MAX_BYTES,
  parameter int QUEUE_DEPTH   = qpd_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        is_final,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  out_byte,
  output logic        closing,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic                accept;
  logic                push;
  logic                pop;
  qpd_pkg::qpd_entry_t push_entry;
  qpd_pkg::qpd_entry_t head;
  qpd_pkg::qpd_qstat_t q_stat;

  // Stall input words while the queue is full
  assign in_stall  = q_stat.full;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  qpd_front #(
    .KEY_MAX_BYTES(KEY_MAX_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_byte),
    .is_final  (is_final),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_entry(push_entry)
  );

  qpd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  qpd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .stat     (q_stat),
    .pop      (pop),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .kind     (kind),
    .out_byte (out_byte),
    .closing  (closing)
  );

  // No word is pushed into a full queue
  assert property (@(posedge clk) disable iff (rst) q_stat.full |-> !push)
    else $error("push into full queue");

  // No word is popped from an empty queue
  assert property (@(posedge clk) disable iff (rst) q_stat.empty |-> !pop)
    else $error("pop from empty queue");

  // Not-found and bad-escape results always close the string
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == qpd_pkg::KIND_NOT_FOUND || kind == qpd_pkg::KIND_BAD_ESCAPE)
      |-> closing)
    else $error("terminal result without closing");

  // A closing result taken while the queue is empty is followed by no valid output
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && closing && q_stat.empty |=> !out_valid)
    else $error("result after closing with empty queue");

endmodule

// ===== test/tb_query_parameter_extract_decode.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_query_parameter_extract_decode: self-checking bench of the query decoder
// Feeds query strings byte by byte, predicts every decoded byte, value end,
// not-found and bad-escape word, and checks each output word in order under
// random idling, random stalls and one long output hold.
// ----------------------------------------------------------------------------
module tb_query_parameter_extract_decode;

  localparam int  SETTLE_CYCLES = 16;
  localparam int  LONG_HOLD     = 400;
  localparam int  PHASE_ITEMS   = 125;
  localparam int  NUM_PHASES    = 10;
  localparam real TIMEOUT_NS    = 3_000_000.0;

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
  } query_item_t;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] data;
    logic       closing;
  } result_word_t;

  typedef enum logic [1:0] {SCAN_KEY, IN_VALUE, VALUE_DONE} scan_state_t;
  typedef enum logic [1:0] {ESC_IDLE, ESC_AFTER_PCT, ESC_AFTER_HIGH} esc_state_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        is_final = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic        closing;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = qpd_pkg::REG_KEY_LOW;
  logic [63:0] cfg_data = 64'h0;

  // Stimulus and checking state
  query_item_t  pending_bytes[$];
  query_item_t  next_item;
  result_word_t decoded_results[$];
  result_word_t want;
  logic [7:0]   query_buf[$];
  int           items_sent = 0;
  int           mismatch_count = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  logic         rx_hold_arm = 1'b0;
  logic         rx_hold_taken = 1'b0;
  int           rx_hold_left = 0;

  // Key used to build strings in the current phase
  logic [7:0]   key_text[qpd_pkg::KEY_MAX_BYTES];
  int           key_used = 2;

  // Predictor copy of the registers and the string state
  logic [63:0]  key_low_reg = 64'h0;
  logic [63:0]  key_high_reg = 64'h0;
  logic [4:0]   key_len_reg = 5'd1;
  logic [7:0]   window[qpd_pkg::KEY_MAX_BYTES] = '{default: 8'h00};
  int           window_fill = 0;
  scan_state_t  scan_state = SCAN_KEY;
  esc_state_t   esc_state = ESC_IDLE;
  logic [3:0]   high_digit = 4'h0;

  query_parameter_extract_decode u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .is_final  (is_final),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .out_byte  (out_byte),
    .closing   (closing),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "a" && c <= "f") return int'(c) - 87;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    return -1;
  endfunction

  function automatic int clamp_key_len(logic [4:0] len);
    if (len < 1) return 1;
    if (len > qpd_pkg::KEY_MAX_BYTES) return qpd_pkg::KEY_MAX_BYTES;
    return int'(len);
  endfunction

  task automatic expect_result(logic [1:0] k, logic [7:0] d, logic c);
    result_word_t w;
    w.kind    = k;
    w.data    = d;
    w.closing = c;
    decoded_results.push_back(w);
  endtask

  // Advance the predicted string state by one accepted query byte
  task automatic decode_query_byte(logic [7:0] b, logic fin);
    logic [127:0] key_all;
    int           n;
    int           i;
    int           h;
    bit           hit;
    key_all = {key_high_reg, key_low_reg};
    n = clamp_key_len(key_len_reg);
    case (scan_state)
      SCAN_KEY: begin
        for (i = qpd_pkg::KEY_MAX_BYTES - 1; i > 0; i--) window[i] = window[i - 1];
        window[0] = b;
        if (window_fill < qpd_pkg::KEY_MAX_BYTES) window_fill++;
        hit = (window_fill >= n);
        for (i = 0; i < n; i++) begin
          if (window[n - 1 - i] != key_all[8 * i +: 8]) hit = 1'b0;
        end
        if (hit) begin
          scan_state = IN_VALUE;
          if (fin) expect_result(qpd_pkg::KIND_END, 8'h00, 1'b1);
        end else if (fin) begin
          expect_result(qpd_pkg::KIND_NOT_FOUND, 8'h00, 1'b1);
        end
      end
      IN_VALUE: begin
        if (esc_state == ESC_IDLE) begin
          if (b == qpd_pkg::CH_AMP) begin
            expect_result(qpd_pkg::KIND_END, 8'h00, 1'b1);
            scan_state = VALUE_DONE;
          end else if (b == qpd_pkg::CH_PERCENT) begin
            esc_state = ESC_AFTER_PCT;
            if (fin) expect_result(qpd_pkg::KIND_BAD_ESCAPE, 8'h00, 1'b1);
          end else begin
            expect_result(qpd_pkg::KIND_BYTE,
                          (b == qpd_pkg::CH_PLUS) ? qpd_pkg::CH_SPACE : b, 1'b0);
            if (fin) expect_result(qpd_pkg::KIND_END, 8'h00, 1'b1);
          end
        end else begin
          h = hex_nibble(b);
          if (h < 0) begin
            expect_result(qpd_pkg::KIND_BAD_ESCAPE, 8'h00, 1'b1);
            scan_state = VALUE_DONE;
          end else if (esc_state == ESC_AFTER_PCT) begin
            high_digit = 4'(h);
            esc_state = ESC_AFTER_HIGH;
            if (fin) expect_result(qpd_pkg::KIND_BAD_ESCAPE, 8'h00, 1'b1);
          end else begin
            expect_result(qpd_pkg::KIND_BYTE, {high_digit, 4'(h)}, 1'b0);
            esc_state = ESC_IDLE;
            high_digit = 4'h0;
            if (fin) expect_result(qpd_pkg::KIND_END, 8'h00, 1'b1);
          end
        end
      end
      default: ;
    endcase
    // A final byte starts the next string from scratch
    if (fin) begin
      for (i = 0; i < qpd_pkg::KEY_MAX_BYTES; i++) window[i] = 8'h00;
      window_fill = 0;
      scan_state = SCAN_KEY;
      esc_state = ESC_IDLE;
      high_digit = 4'h0;
    end
  endtask

  // Drive the input word and predict on each accepted one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) decode_query_byte(in_byte, is_final);
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = pending_bytes.pop_front();
          in_valid <= 1'b1;
          in_byte  <= next_item.b;
          is_final <= next_item.fin;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Count down the one long output hold
  always @(posedge clk) begin
    if (rst) begin
      rx_hold_left  <= 0;
      rx_hold_taken <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_arm && !rx_hold_taken) begin
      rx_hold_left  <= LONG_HOLD;
      rx_hold_taken <= 1'b1;
    end
  end

  // Check each output word against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (decoded_results.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual kind %0d byte %02h closing %0d",
                   $time, kind, out_byte, closing);
          mismatch_count++;
        end else begin
          want = decoded_results.pop_front();
          if (kind !== want.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind);
            mismatch_count++;
          end
          if (out_byte !== want.data) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, want.data, out_byte);
            mismatch_count++;
          end
          if (closing !== want.closing) begin
            $display("%0t: closing expected %0d actual %0d", $time, want.closing, closing);
            mismatch_count++;
          end
        end
      end
      out_stall <= (rx_hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [63:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      qpd_pkg::REG_KEY_LOW:  key_low_reg = value;
      qpd_pkg::REG_KEY_HIGH: key_high_reg = value;
      qpd_pkg::REG_KEY_LEN:  key_len_reg = value[4:0];
      default: ;
    endcase
  endtask

  // Hold until every word is accepted and every result has come back
  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_valid || decoded_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_text(string s, bit mark_final);
    int i;
    for (i = 0; i < s.len(); i++)
      pending_bytes.push_back('{s[i], mark_final && (i == s.len() - 1)});
    items_sent += s.len();
  endtask

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(15);
    if (v < 10) return 8'(8'h30 + v);
    return $urandom_range(1) ? 8'(8'h41 + v - 10) : 8'(8'h61 + v - 10);
  endfunction

  // Append one value: plain bytes, plus signs, good and broken escapes
  task automatic add_value();
    int         tokens;
    int         r;
    logic [7:0] b;
    tokens = $urandom_range(6);
    repeat (tokens) begin
      r = $urandom_range(99);
      if (r < 50) begin
        do b = 8'($urandom_range(255));
        while (b == qpd_pkg::CH_AMP || b == qpd_pkg::CH_PERCENT);
        query_buf.push_back(b);
      end else if (r < 65) begin
        query_buf.push_back(qpd_pkg::CH_PLUS);
      end else if (r < 90) begin
        query_buf.push_back(qpd_pkg::CH_PERCENT);
        query_buf.push_back(rand_hex_char());
        query_buf.push_back(rand_hex_char());
      end else begin
        query_buf.push_back(qpd_pkg::CH_PERCENT);
        if ($urandom_range(1)) query_buf.push_back(rand_hex_char());
        do b = 8'($urandom_range(255)); while (hex_nibble(b) >= 0);
        query_buf.push_back(b);
      end
    end
  endtask

  // Build one query string, mostly well formed with the key somewhere
  task automatic build_query();
    int params;
    int key_at;
    int p;
    int k;
    int cut;
    query_buf.delete();
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 20)) query_buf.push_back(8'($urandom_range(255)));
    end else begin
      params = $urandom_range(1, 3);
      key_at = ($urandom_range(99) < 85) ? $urandom_range(params - 1) : params;
      for (p = 0; p < params; p++) begin
        if (p != 0) query_buf.push_back(qpd_pkg::CH_AMP);
        if (p == key_at) begin
          for (k = 0; k < key_used; k++) query_buf.push_back(key_text[k]);
        end else begin
          repeat ($urandom_range(1, 4)) query_buf.push_back(8'(8'h61 + $urandom_range(25)));
          query_buf.push_back("=");
        end
        add_value();
      end
    end
    // Cut some strings short by up to three bytes, which can end them inside a key or an escape
    if (query_buf.size() > 1 && $urandom_range(99) < 10) begin
      cut = $urandom_range(1, (query_buf.size() - 1 < 3) ? query_buf.size() - 1 : 3);
      repeat (cut) void'(query_buf.pop_back());
    end
    foreach (query_buf[k])
      pending_bytes.push_back('{query_buf[k], k == query_buf.size() - 1});
    items_sent += query_buf.size();
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("tb_query_parameter_extract_decode NOT OK");
    $finish;
  end

  initial begin
    logic [4:0]  len_table[NUM_PHASES];
    logic [63:0] low_word;
    logic [63:0] high_word;
    int          ph;
    int          k;
    int          target;
    len_table = '{5'd2, 5'd0, 5'd16, 5'd31, 5'd1, 5'd17, 5'd0, 5'd0, 5'd5, 5'd0};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed strings with key "k="
    write_reg(qpd_pkg::REG_KEY_LOW, 64'h3D6B);
    write_reg(qpd_pkg::REG_KEY_HIGH, 64'h0);
    write_reg(qpd_pkg::REG_KEY_LEN, 64'd2);
    send_text("k=+%4a%F0", 1'b1);
    send_text("k=", 1'b1);
    send_text("k=%", 1'b1);
    send_text("k=%g", 1'b1);
    pending_bytes.push_back('{8'h00, 1'b0});
    pending_bytes.push_back('{8'hFF, 1'b1});
    items_sent += 2;
    send_text("ab", 1'b0);
    wait_idle();
    // Change the key in the middle of a string: it applies to the next compare
    write_reg(qpd_pkg::REG_KEY_LOW, 64'h3D6B62);
    write_reg(qpd_pkg::REG_KEY_LEN, 64'd3);
    send_text("k=z", 1'b1);

    // Random phases, each with its own key and idling mode
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      if (len_table[ph] == 5'd0 && ph != 1) len_table[ph] = 5'($urandom_range(31));
      key_used = clamp_key_len(len_table[ph]);
      for (k = 0; k < qpd_pkg::KEY_MAX_BYTES; k++) begin
        if (ph == 5 || k >= key_used) key_text[k] = 8'($urandom_range(255));
        else if (k == key_used - 1) key_text[k] = "=";
        else key_text[k] = 8'(8'h61 + $urandom_range(25));
      end
      for (k = 0; k < 8; k++) begin
        low_word[8 * k +: 8]  = key_text[k];
        high_word[8 * k +: 8] = key_text[k + 8];
      end
      write_reg(qpd_pkg::REG_KEY_LOW, low_word);
      write_reg(qpd_pkg::REG_KEY_HIGH, high_word);
      write_reg(qpd_pkg::REG_KEY_LEN, {59'd0, len_table[ph]});
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      // Hold the output long enough for the block to fill and stall its input
      if (ph == 4) rx_hold_arm <= 1'b1;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) build_query();
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("tb_query_parameter_extract_decode OK");
    end else begin
      $display("tb_query_parameter_extract_decode NOT OK");
    end
    $finish;
  end

endmodule
